[src/kscavg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kscavg_pkg;

    localparam int KEY_W        = 8;
    localparam int DATA_W       = 32;
    localparam int KEY_SPACE    = 2 ** KEY_W;
    localparam int NUM_KEYS_DEF = 256;
    // wide enough to hold the key space size and the default key count
    localparam int CMP_W        = 17;
    localparam int STEP_W       = $clog2(DATA_W);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [DATA_W-1:0] CNT_MAX = '1;

endpackage

`default_nettype wire

[src/keyed_sum_count_average.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake            | payload
// --------+----------------------+--------------------------------------------
// in      | in_valid / in_stall  | cmd, key, value
// out     | out_valid / out_stall| has_entries, total, entry_count, mean
//
// inserts are accepted back to back, with the read-modify-write of sum and
// count forwarded when the same key follows
// a read word gives its result word after the modify stage, 32 bit-serial
// divider steps and the output load, and the divider waits for a free output
// a second read waits in the modify stage until the divider is idle again
// reset clears the per-key valid bits at once, so no clearing pass is needed
// a stalled output keeps its word; the divider holds its result until the
// output register is free

module keyed_sum_count_average
    import kscavg_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     cmd,
    input  wire logic [KEY_W-1:0]         key,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          has_entries,
    output logic signed [DATA_W-1:0]      total,
    output logic [DATA_W-1:0]             entry_count,
    output logic signed [DATA_W-1:0]      mean
);

    localparam int MEM_DEPTH = (NUM_KEYS < KEY_SPACE) ? NUM_KEYS : KEY_SPACE;
    localparam int IDX_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [1:0] DIV_IDLE = 2'd0;
    localparam logic [1:0] DIV_RUN  = 2'd1;
    localparam logic [1:0] DIV_DONE = 2'd2;

    // storage
    logic [DATA_W-1:0]    mem_sum [MEM_DEPTH];
    logic [DATA_W-1:0]    mem_cnt [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;

    // input side
    logic             in_acc;
    logic             in_range;
    logic [IDX_W-1:0] in_idx;

    // modify stage
    logic              s1_vld_reg, s1_vld_next;
    logic              s1_cmd_reg;
    logic              s1_inr_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [DATA_W-1:0] s1_val_reg;
    logic [DATA_W-1:0] rd_sum_reg, rd_cnt_reg;
    logic              rd_hit_reg;
    logic              s1_go;
    logic              mem_we;

    // last write, for a read that raced it
    logic              fwd_vld_reg;
    logic [IDX_W-1:0]  fwd_idx_reg;
    logic [DATA_W-1:0] fwd_sum_reg, fwd_cnt_reg;
    logic              fwd_hit;

    logic [DATA_W-1:0] eff_sum, eff_cnt;
    logic [DATA_W-1:0] new_sum, new_cnt;

    // divider
    logic [1:0]        div_state_reg, div_state_next;
    logic [STEP_W-1:0] div_step_reg, div_step_next;
    logic              div_start;
    logic [DATA_W-1:0] div_rem_reg, div_quo_reg, div_dvs_reg, div_sum_reg;
    logic              div_neg_reg;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W+1:0] rem_diff;
    logic [DATA_W-1:0] rem_nx, quo_nx;
    logic [DATA_W-1:0] dvd_mag;
    logic [DATA_W-1:0] mean_val;

    // output register
    logic              out_vld_reg, out_vld_next;
    logic              out_free;
    logic              out_load;
    logic              out_has_reg;
    logic [DATA_W-1:0] out_sum_reg, out_cnt_reg, out_mean_reg;

    assign in_acc   = in_valid && !in_stall;
    assign in_range = {{(CMP_W-KEY_W){1'b0}}, key} < CMP_W'(NUM_KEYS);
    assign in_idx   = key[IDX_W-1:0];

    assign s1_go    = s1_vld_reg && ((s1_cmd_reg == CMD_INSERT) || (div_state_reg == DIV_IDLE));
    assign in_stall = s1_vld_reg && !s1_go;
    assign mem_we   = s1_vld_reg && (s1_cmd_reg == CMD_INSERT) && s1_inr_reg;
    assign div_start = s1_go && (s1_cmd_reg == CMD_READ);

    assign fwd_hit = fwd_vld_reg && (fwd_idx_reg == s1_idx_reg);

    always_comb
    begin
        priority if (!s1_inr_reg)
        begin
            eff_sum = '0;
            eff_cnt = '0;
        end
        else if (fwd_hit)
        begin
            eff_sum = fwd_sum_reg;
            eff_cnt = fwd_cnt_reg;
        end
        else if (rd_hit_reg)
        begin
            eff_sum = rd_sum_reg;
            eff_cnt = rd_cnt_reg;
        end
        else
        begin
            eff_sum = '0;
            eff_cnt = '0;
        end
    end

    assign new_sum = eff_sum + s1_val_reg;
    assign new_cnt = (eff_cnt == CNT_MAX) ? eff_cnt : eff_cnt + 1'b1;

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (in_acc)
        begin
            s1_vld_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_vld_next = 1'b0;
        end
    end

    // memories: read-old on a same-edge write, covered by the forward register
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_sum[s1_idx_reg] <= new_sum;
            mem_cnt[s1_idx_reg] <= new_cnt;
        end
        if (in_acc)
        begin
            rd_sum_reg <= mem_sum[in_idx];
            rd_cnt_reg <= mem_cnt[in_idx];
        end
    end

    // divider step: restoring, one quotient bit a cycle
    assign rem_sh   = {div_rem_reg, div_quo_reg[DATA_W-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, div_dvs_reg};
    assign rem_nx   = rem_diff[DATA_W+1] ? rem_sh[DATA_W-1:0] : rem_diff[DATA_W-1:0];
    assign quo_nx   = {div_quo_reg[DATA_W-2:0], ~rem_diff[DATA_W+1]};
    assign dvd_mag  = eff_sum[DATA_W-1] ? (~eff_sum + 1'b1) : eff_sum;

    always_comb
    begin
        div_state_next = div_state_reg;
        div_step_next  = div_step_reg;
        unique case (div_state_reg)
            DIV_IDLE:
            begin
                if (div_start)
                begin
                    div_state_next = DIV_RUN;
                    div_step_next  = '1;
                end
            end
            DIV_RUN:
            begin
                div_step_next = div_step_reg - 1'b1;
                if (div_step_reg == '0)
                begin
                    div_state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                if (out_free)
                begin
                    div_state_next = DIV_IDLE;
                end
            end
            default:
            begin
                div_state_next = DIV_IDLE;
            end
        endcase
    end

    assign mean_val = (div_dvs_reg == '0) ? '0 :
                      (div_neg_reg ? (~div_quo_reg + 1'b1) : div_quo_reg);

    assign out_free = !out_vld_reg || !out_stall;
    assign out_load = (div_state_reg == DIV_DONE) && out_free;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            fwd_vld_reg   <= 1'b0;
            valid_reg     <= '0;
            div_state_reg <= DIV_IDLE;
            div_step_reg  <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg    <= s1_vld_next;
            div_state_reg <= div_state_next;
            div_step_reg  <= div_step_next;
            out_vld_reg   <= out_vld_next;
            if (mem_we)
            begin
                fwd_vld_reg           <= 1'b1;
                valid_reg[s1_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_cmd_reg <= cmd;
            s1_inr_reg <= in_range;
            s1_idx_reg <= in_idx;
            s1_val_reg <= value;
            rd_hit_reg <= valid_reg[in_idx];
        end
        if (mem_we)
        begin
            fwd_idx_reg <= s1_idx_reg;
            fwd_sum_reg <= new_sum;
            fwd_cnt_reg <= new_cnt;
        end
        if (div_start)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= dvd_mag;
            div_dvs_reg <= eff_cnt;
            div_sum_reg <= eff_sum;
            div_neg_reg <= eff_sum[DATA_W-1];
        end
        else if (div_state_reg == DIV_RUN)
        begin
            div_rem_reg <= rem_nx;
            div_quo_reg <= quo_nx;
        end
        if (out_load)
        begin
            out_has_reg  <= (div_dvs_reg != '0);
            out_sum_reg  <= div_sum_reg;
            out_cnt_reg  <= div_dvs_reg;
            out_mean_reg <= mean_val;
        end
    end

    assign out_valid   = out_vld_reg;
    assign has_entries = out_has_reg;
    assign total       = $signed(out_sum_reg);
    assign entry_count = out_cnt_reg;
    assign mean        = $signed(out_mean_reg);

endmodule

`default_nettype wire

[src/kscavg_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module kscavg_chk
    import kscavg_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_stall,
    input wire logic                     cmd,
    input wire logic                     out_valid,
    input wire logic                     out_stall,
    input wire logic                     has_entries,
    input wire logic signed [DATA_W-1:0] total,
    input wire logic [DATA_W-1:0]        entry_count,
    input wire logic signed [DATA_W-1:0] mean
);

    // a held output word keeps its fields
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(total) && $stable(entry_count)
            && $stable(mean) && $stable(has_entries))
        else $error("output word changed while stalled");

    // an insert leaves the modify stage without stalling the input behind it
    a_insert_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == CMD_INSERT) |=> !in_stall)
        else $error("input stalled behind an insert");

    // a second read right behind the first waits on the divider
    a_read_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (cmd == CMD_READ))
            ##1 (in_valid && !in_stall && (cmd == CMD_READ)) |=> in_stall)
        else $error("two reads accepted while divider busy");

    // the entry flag matches the count, and an empty key reads as all zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (has_entries == (entry_count != '0))
            && (has_entries || ((total == '0) && (mean == '0))))
        else $error("inconsistent empty-key word");

endmodule

bind keyed_sum_count_average kscavg_chk u_kscavg_chk (.*);

`default_nettype wire
